FILE: design/aes_block_cipher_unit_assert.svh
// assertion helpers for the cipher unit
`ifndef AES_BLOCK_CIPHER_UNIT_ASSERT_SVH
`define AES_BLOCK_CIPHER_UNIT_ASSERT_SVH

// same-cycle implication
`define AES_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/aes_pkg.sv
package aes_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_WHITEN,
    ST_ROUND
  } state_t;

  localparam logic [2:0] REG_KEY_SIZE = 3'd0;
  localparam logic [2:0] REG_KEY_01   = 3'd1;
  localparam logic [2:0] REG_KEY_23   = 3'd2;
  localparam logic [2:0] REG_KEY_45   = 3'd3;
  localparam logic [2:0] REG_KEY_67   = 3'd4;

  localparam logic [7:0] POLY_LOW = 8'h1b;
  localparam logic [31:0] FWD_M = 32'h02030101;
  localparam logic [31:0] INV_M = 32'h0e0b0d09;

  localparam logic [2047:0] SBOX_TBL = {
    128'h637c777bf26b6fc53001672bfed7ab76,
    128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115,
    128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84,
    128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8,
    128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973,
    128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479,
    128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
    128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df,
    128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [2047:0] RSBOX_TBL = {
    128'h52096ad53036a538bf40a39e81f3d7fb,
    128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e,
    128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692,
    128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506,
    128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673,
    128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b,
    128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f,
    128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961,
    128'h172b047eba77d626e169146355210c7d
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX_TBL[2047 - 8 * int'(b) -: 8];
  endfunction

  function automatic logic [7:0] rsbox(input logic [7:0] b);
    return RSBOX_TBL[2047 - 8 * int'(b) -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return a[7] ? ({a[6:0], 1'b0} ^ POLY_LOW) : {a[6:0], 1'b0};
  endfunction

  function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = '0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x;
      x = xtime(x);
    end
    return r;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (4 * c + r) -: 8] = sbox(s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = rsbox(s[127 - 8 * (4 * c + r) -: 8]);
      end
    end
    return t;
  endfunction

  // column mix with coefficient row m, rotated per output byte
  function automatic logic [127:0] mix(input logic [127:0] s, input logic [31:0] m);
    logic [127:0] t;
    logic [7:0] v;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        v = '0;
        for (int k = 0; k < 4; k++) begin
          v = v ^ fmul(s[127 - 8 * (4 * c + k) -: 8], m[31 - 8 * ((k + 4 - r) % 4) -: 8]);
        end
        t[127 - 8 * (4 * c + r) -: 8] = v;
      end
    end
    return t;
  endfunction

endpackage

FILE: design/aes_block_cipher_unit.sv
// channel  | dir | handshake                | payload
// in_      | in  | in_tvalid / in_tready    | tdata: block_high, block_low; tuser: mode
// out_     | out | out_tvalid / out_tready  | tdata: result_high, result_low
// cfg_     | in  | psel, penable, pready    | 64-bit registers at 8*i
//
// a block takes one load of round key 0 or nr, then one round per cycle (the final round
// may hold) on the shared round unit, paced by the round key memory read.
// after reset and after any key or key_size write the schedule is expanded first,
// one word per cycle, 44, 52 or 60 words in all, during which no block is taken.
// a finished result waits in the output register; the final round holds while it is full.
module aes_block_cipher_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // block_high [63:0], block_low [127:64]
  input  logic         in_tuser,   // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // result_high [63:0], result_low [127:64]
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [5:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);
  import aes_pkg::*;

  state_t st_r, st_nxt;

  logic [1:0]   key_size_r;
  logic [63:0]  key_r [4];
  logic         dirty_r, dirty_nxt;

  logic [127:0] rk_mem [16];
  logic [127:0] rk_q;
  logic [3:0]   rd_row;
  logic         wr_en;
  logic [3:0]   wr_row;
  logic [127:0] wr_data;

  logic [31:0]  win_r [8];
  logic [5:0]   wi_r, wi_nxt;
  logic [2:0]   wj_r, wj_nxt;
  logic [7:0]   rc_r, rc_nxt;
  logic [31:0]  new_word, tw, far_word;

  logic [127:0] s_r, s_nxt;
  logic         dec_r, dec_nxt;
  logic [3:0]   cnt_r, cnt_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [127:0] out_data_r, out_data_nxt;

  logic [1:0]   sel;
  logic [3:0]   nk, nr;
  logic [2:0]   reg_idx;
  logic         cfg_wr;
  logic         shift_en;
  logic         out_free;

  assign sel     = (key_size_r == 2'd0) ? 2'd0 : ((key_size_r == 2'd1) ? 2'd1 : 2'd2);
  assign nk      = 4'd4 + {1'b0, sel, 1'b0};
  assign nr      = nk + 4'd6;
  assign reg_idx = cfg_paddr[5:3];
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    unique case (reg_idx)
      REG_KEY_SIZE: cfg_prdata = {62'd0, key_size_r};
      REG_KEY_01:   cfg_prdata = key_r[0];
      REG_KEY_23:   cfg_prdata = key_r[1];
      REG_KEY_45:   cfg_prdata = key_r[2];
      REG_KEY_67:   cfg_prdata = key_r[3];
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_size_r <= '0;
      for (int k = 0; k < 4; k++) key_r[k] <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_KEY_SIZE: key_size_r <= cfg_pwdata[1:0];
        REG_KEY_01:   key_r[0] <= cfg_pwdata;
        REG_KEY_23:   key_r[1] <= cfg_pwdata;
        REG_KEY_45:   key_r[2] <= cfg_pwdata;
        REG_KEY_67:   key_r[3] <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // key schedule word generation
  always_comb begin
    case (nk)
      4'd4:    far_word = win_r[3];
      4'd6:    far_word = win_r[5];
      default: far_word = win_r[7];
    endcase
    if (wj_r == 3'd0) begin
      tw = sub_word({win_r[0][23:0], win_r[0][31:24]}) ^ {rc_r, 24'd0};
    end else if (nk == 4'd8 && wj_r == 3'd4) begin
      tw = sub_word(win_r[0]);
    end else begin
      tw = win_r[0];
    end
    if (wi_r < {2'b00, nk}) begin
      new_word = wi_r[0] ? key_r[wi_r[2:1]][31:0] : key_r[wi_r[2:1]][63:32];
    end else begin
      new_word = far_word ^ tw;
    end
    wr_row  = wi_r[5:2];
    wr_data = {win_r[2], win_r[1], win_r[0], new_word};
  end

  always_ff @(posedge clk) begin
    if (wr_en) rk_mem[wr_row] <= wr_data;
    rk_q <= rk_mem[rd_row];
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int k = 7; k > 0; k--) win_r[k] <= win_r[k-1];
      win_r[0] <= new_word;
    end
  end

  always_comb begin
    st_nxt        = st_r;
    dirty_nxt     = dirty_r;
    wi_nxt        = wi_r;
    wj_nxt        = wj_r;
    rc_nxt        = rc_r;
    s_nxt         = s_r;
    dec_nxt       = dec_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    in_tready     = 1'b0;
    shift_en      = 1'b0;
    wr_en         = 1'b0;
    rd_row        = dec_r ? nr : 4'd0;
    unique case (st_r)
      ST_IDLE: begin
        in_tready = !dirty_r;
        rd_row    = in_tuser ? nr : 4'd0;
        if (dirty_r) begin
          st_nxt = ST_EXPAND;
          wi_nxt = '0;
          wj_nxt = '0;
          rc_nxt = 8'h01;
        end else if (in_tvalid) begin
          s_nxt   = {in_tdata[63:0], in_tdata[127:64]};
          dec_nxt = in_tuser;
          st_nxt  = ST_WHITEN;
        end
      end
      ST_EXPAND: begin
        shift_en = 1'b1;
        wr_en    = (wi_r[1:0] == 2'd3);
        wi_nxt   = wi_r + 6'd1;
        wj_nxt   = (wj_r == nk[2:0] - 3'd1) ? 3'd0 : wj_r + 3'd1;
        if (wj_r == 3'd0 && wi_r >= {2'b00, nk}) rc_nxt = xtime(rc_r);
        if (wi_r == {nr, 2'd3}) begin
          st_nxt    = ST_IDLE;
          dirty_nxt = 1'b0;
        end
      end
      ST_WHITEN: begin
        s_nxt   = s_r ^ rk_q;
        cnt_nxt = 4'd1;
        rd_row  = dec_r ? nr - 4'd1 : 4'd1;
        st_nxt  = ST_ROUND;
      end
      ST_ROUND: begin
        if (cnt_r != nr) begin
          rd_row  = dec_r ? nr - cnt_r - 4'd1 : cnt_r + 4'd1;
          cnt_nxt = cnt_r + 4'd1;
          s_nxt   = dec_r ? mix(inv_sub_shift(s_r) ^ rk_q, INV_M)
                          : mix(sub_shift(s_r), FWD_M) ^ rk_q;
        end else begin
          // hold the last round key while the output register is full
          rd_row = dec_r ? 4'd0 : nr;
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = dec_r ? (inv_sub_shift(s_r) ^ rk_q) : (sub_shift(s_r) ^ rk_q);
            st_nxt        = ST_IDLE;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (cfg_wr && reg_idx <= REG_KEY_67) begin
      dirty_nxt = 1'b1;
      if (st_r == ST_EXPAND) st_nxt = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      dirty_r     <= 1'b1;
      out_valid_r <= 1'b0;
      wi_r        <= '0;
      wj_r        <= '0;
      rc_r        <= 8'h01;
      cnt_r       <= '0;
      dec_r       <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
      wi_r        <= wi_nxt;
      wj_r        <= wj_nxt;
      rc_r        <= rc_nxt;
      cnt_r       <= cnt_nxt;
      dec_r       <= dec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r        <= s_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r[63:0], out_data_r[127:64]};

`include "aes_block_cipher_unit_assert.svh"

  `AES_ASSERT_SAME(a_no_stale_schedule, in_tvalid && in_tready, !dirty_r, "block taken with stale key schedule")
  `AES_ASSERT_SAME(a_round_bound, st_r == ST_ROUND, cnt_r != 4'd0 && cnt_r <= nr, "round count out of range")
  `AES_ASSERT_NEXT(a_result_loaded, st_r == ST_ROUND && cnt_r == nr && out_free, out_valid_r, "final round lost its result")

endmodule

FILE: tb/sv/tb_aes_block_cipher_unit.sv
module tb_aes_block_cipher_unit;
  import aes_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // block_high [63:0], block_low [127:64]
  logic         in_tuser = 1'b0; // mode
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;       // result_high [63:0], result_low [127:64]
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [5:0]   cfg_paddr = '0;
  logic [63:0]  cfg_pwdata = '0;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;
  localparam logic [2:0] REG_UNMAPPED = 3'd5;
  localparam logic [2:0] REG_UNMAPPED_TOP = 3'd7;

  aes_block_cipher_unit u_top (.*);

  always #5 clk = ~clk;

  // predictor copy of the configuration and the schedule
  logic [1:0]  key_sz_q = '0;
  logic [63:0] key_reg_q [4] = '{default: '0};
  logic [31:0] sched_words [60];
  logic [7:0]  fwd_sub [256];
  logic [7:0]  inv_sub [256];

  logic [127:0] expected_results [$];
  int errors = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  function automatic logic [7:0] gf_dbl(logic [7:0] a);
    return a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = gf_dbl(a);
    end
    return r;
  endfunction

  // s-box from the field inverse and the affine map
  task automatic build_boxes();
    logic [7:0] inv;
    logic [7:0] s;
    for (int x = 0; x < 256; x++) begin
      inv = '0;
      for (int y = 1; y < 256; y++)
        if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_sub[x] = s;
    end
    for (int x = 0; x < 256; x++) inv_sub[fwd_sub[x]] = 8'(x);
  endtask

  function automatic int expand_schedule();
    int sel;
    int nk;
    int nr;
    logic [7:0] rc;
    logic [31:0] t;
    sel = (key_sz_q == 2'd3) ? 2 : int'(key_sz_q);
    nk = 4 + 2 * sel;
    nr = nk + 6;
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      sched_words[i] = i[0] ? key_reg_q[i >> 1][31:0] : key_reg_q[i >> 1][63:32];
    for (int i = nk; i < 4 * (nr + 1); i++) begin
      t = sched_words[i - 1];
      if (i % nk == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fwd_sub[t[31:24]], fwd_sub[t[23:16]], fwd_sub[t[15:8]], fwd_sub[t[7:0]]}
            ^ {rc, 24'h0};
        rc = gf_dbl(rc);
      end else if (nk == 8 && i % nk == 4) begin
        t = {fwd_sub[t[31:24]], fwd_sub[t[23:16]], fwd_sub[t[15:8]], fwd_sub[t[7:0]]};
      end
      sched_words[i] = sched_words[i - nk] ^ t;
    end
    return nr;
  endfunction

  function automatic void add_round_key(ref logic [7:0] st [16], input int rnd);
    logic [31:0] w;
    for (int c = 0; c < 4; c++) begin
      w = sched_words[4 * rnd + c];
      for (int r = 0; r < 4; r++) st[4 * c + r] ^= w[31 - 8 * r -: 8];
    end
  endfunction

  function automatic void subst_rows(ref logic [7:0] st [16], input logic dec);
    logic [7:0] t [16];
    int mv;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        mv = r + 4 * ((c + r) % 4);
        if (dec) t[mv] = inv_sub[st[4 * c + r]];
        else t[4 * c + r] = fwd_sub[st[mv]];
      end
    st = t;
  endfunction

  function automatic void mix_cols(ref logic [7:0] st [16], input logic dec);
    logic [7:0] coef [4];
    logic [7:0] col [4];
    if (dec) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else coef = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        col[r] = '0;
        for (int k = 0; k < 4; k++) col[r] ^= gf_mul(st[4 * c + k], coef[(k + 4 - r) % 4]);
      end
      for (int r = 0; r < 4; r++) st[4 * c + r] = col[r];
    end
  endfunction

  // returns {result_low, result_high} as the output port packs it
  function automatic logic [127:0] cipher_block(logic dec, logic [63:0] hi, logic [63:0] lo);
    logic [7:0] st [16];
    logic [63:0] rh;
    logic [63:0] rl;
    int nr;
    nr = expand_schedule();
    for (int i = 0; i < 8; i++) begin
      st[i] = hi[63 - 8 * i -: 8];
      st[8 + i] = lo[63 - 8 * i -: 8];
    end
    if (!dec) begin
      add_round_key(st, 0);
      for (int rnd = 1; rnd < nr; rnd++) begin
        subst_rows(st, 1'b0);
        mix_cols(st, 1'b0);
        add_round_key(st, rnd);
      end
      subst_rows(st, 1'b0);
      add_round_key(st, nr);
    end else begin
      add_round_key(st, nr);
      for (int rnd = nr - 1; rnd > 0; rnd--) begin
        subst_rows(st, 1'b1);
        add_round_key(st, rnd);
        mix_cols(st, 1'b1);
      end
      subst_rows(st, 1'b1);
      add_round_key(st, 0);
    end
    for (int i = 0; i < 8; i++) begin
      rh[63 - 8 * i -: 8] = st[i];
      rl[63 - 8 * i -: 8] = st[8 + i];
    end
    return {rl, rh};
  endfunction

  // result side: random stall, compare each beat with the oldest expectation
  always @(posedge clk) begin
    logic [127:0] exp_v;
    out_tready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %h", $time, out_tdata);
      end else begin
        exp_v = expected_results.pop_front();
        if (out_tdata[63:0] !== exp_v[63:0]) begin
          errors++;
          $display("%0t: result_high expected %h actual %h", $time, exp_v[63:0],
                   out_tdata[63:0]);
        end
        if (out_tdata[127:64] !== exp_v[127:64]) begin
          errors++;
          $display("%0t: result_low expected %h actual %h", $time, exp_v[127:64],
                   out_tdata[127:64]);
        end
      end
    end
  end

  task automatic send_block(logic mode, logic [63:0] hi, logic [63:0] lo);
    if ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {lo, hi};
    in_tuser <= mode;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(cipher_block(mode, hi, lo));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    drain();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_KEY_SIZE) key_sz_q = value[1:0];
    else if (idx <= REG_KEY_67) key_reg_q[idx - 1] = value;
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic load_key(logic [1:0] sz, logic [63:0] k0, logic [63:0] k1,
                          logic [63:0] k2, logic [63:0] k3);
    write_reg(REG_KEY_SIZE, {62'h0, sz});
    write_reg(REG_KEY_01, k0);
    write_reg(REG_KEY_23, k1);
    write_reg(REG_KEY_45, k2);
    write_reg(REG_KEY_67, k3);
  endtask

  task automatic test_extremes();
    for (int sz = 0; sz < 4; sz++) begin
      load_key(2'(sz), '0, '0, '0, '0);
      send_block(MODE_ENC, '0, '0);
      send_block(MODE_DEC, '1, '1);
      load_key(2'(sz), '1, '1, '1, '1);
      send_block(MODE_ENC, '1, '0);
      send_block(MODE_DEC, '0, '1);
    end
  endtask

  task automatic test_unused_words();
    // words past the key length must not change the result
    load_key(2'd0, 64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, '1, '1);
    send_block(MODE_ENC, 64'h3243f6a8885a308d, 64'h313198a2e0370734);
    write_reg(REG_KEY_45, 64'h0123456789abcdef);
    send_block(MODE_ENC, 64'h3243f6a8885a308d, 64'h313198a2e0370734);
    // unmapped register: no effect
    write_reg(REG_UNMAPPED, '1);
    write_reg(REG_UNMAPPED_TOP, 64'h5a5a5a5a5a5a5a5a);
    send_block(MODE_DEC, 64'h3925841d02dc09fb, 64'hdc118597196a0b32);
  endtask

  task automatic test_random(int gap, int stall, int n);
    gap_pct = gap;
    stall_pct = stall;
    for (int k = 0; k < n; k++) begin
      if (k % 60 == 0)
        load_key(2'($urandom_range(3)), rand64(), rand64(), rand64(), rand64());
      send_block(1'($urandom_range(1)), rand64(), rand64());
    end
  endtask

  initial begin
    build_boxes();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_unused_words();
    test_random(0, 0, 270);
    test_random(88, 0, 270);
    test_random(0, 88, 270);
    test_random(29, 29, 270);
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
